@@ hdl/ctd_pkg.sv @@
// ----------------------------------------------------------------------------
// ctd_pkg
// Shared types and constants of the changed tile detector: word layouts,
// configuration register codes, reset values and default size limits.
// ----------------------------------------------------------------------------
package ctd_pkg;

    // Default size limits, handed to the top level parameters
    localparam int DEF_MAX_TILE_COLUMNS = 32;
    localparam int DEF_MAX_FRAME_WIDTH  = 2048;
    localparam int DEF_MAX_FRAME_HEIGHT = 2048;

    // Field widths
    localparam int PIXEL_PAIR_W   = 32;
    localparam int ROW_MASK_W     = 32;
    localparam int TILE_ROW_W     = 11;
    localparam int CHANGED_W      = 17;
    localparam int CFG_DATA_W     = 12;
    localparam int FRAME_DIM_W    = 12;
    localparam int TILE_DIM_W     = 9;
    localparam int TILE_WORD_W    = 7;   // word index inside a tile, up to 127
    localparam int TILE_LINE_W    = 8;   // line index inside a tile, up to 255

    // Register values after reset
    localparam logic [FRAME_DIM_W-1:0] RST_FRAME_WIDTH  = 12'd320;
    localparam logic [FRAME_DIM_W-1:0] RST_FRAME_HEIGHT = 12'd240;
    localparam logic [TILE_DIM_W-1:0]  RST_TILE_WIDTH   = 9'd64;
    localparam logic [TILE_DIM_W-1:0]  RST_TILE_HEIGHT  = 9'd30;

    // Configuration register codes
    typedef enum logic [1:0] {
        CFG_FRAME_WIDTH  = 2'd0,
        CFG_FRAME_HEIGHT = 2'd1,
        CFG_TILE_WIDTH   = 2'd2,
        CFG_TILE_HEIGHT  = 2'd3
    } cfg_index_t;

    // Input word: current and previous pixel pair
    typedef struct packed {
        logic [PIXEL_PAIR_W-1:0] current_pair;
        logic [PIXEL_PAIR_W-1:0] previous_pair;
    } pair_word_t;

    // Result word: one per finished tile row
    typedef struct packed {
        logic [ROW_MASK_W-1:0] row_mask;
        logic [TILE_ROW_W-1:0] tile_row;
        logic [CHANGED_W-1:0]  changed_total;
        logic                  frame_end;
    } row_result_t;

endpackage

@@ hdl/changed_tile_detector_top.sv @@
// ----------------------------------------------------------------------------
// changed_tile_detector_top
// Compares a raster stream of current/previous pixel pair words, marks tiles
// that hold a differing word and emits a dirty mask per finished tile row.
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake            payload
//  in       input      in_valid / in_stall  in_word  (pair_word_t)
//  out      output     out_valid/out_stall  out_word (row_result_t)
//  cfg      input      cfg_write            cfg_index, cfg_data
//
//  One word per cycle while in_stall is low; an accepted word enters the compare
//  register, and as it leaves it the word counters update and, if it closes a
//  tile row, its row result is written to the output register.
//  A word that closes a tile row waits in the compare register while an
//  untaken result occupies the output register; other words keep flowing.
//  Reset clears all counters and loads the register defaults; no clear pass.
//
module changed_tile_detector_top #(
    parameter int MAX_TILE_COLUMNS = ctd_pkg::DEF_MAX_TILE_COLUMNS,
    parameter int MAX_FRAME_WIDTH  = ctd_pkg::DEF_MAX_FRAME_WIDTH,
    parameter int MAX_FRAME_HEIGHT = ctd_pkg::DEF_MAX_FRAME_HEIGHT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  ctd_pkg::pair_word_t                 in_word,
    output logic                                out_valid,
    input  logic                                out_stall,
    output ctd_pkg::row_result_t                out_word,
    input  logic                                cfg_write,
    input  ctd_pkg::cfg_index_t                 cfg_index,
    input  logic [ctd_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import ctd_pkg::*;

    localparam int WL_W = $clog2(MAX_FRAME_WIDTH / 2);   // word in line
    localparam int LW_W = WL_W + 1;                      // words per line
    localparam int LF_W = $clog2(MAX_FRAME_HEIGHT);      // line in frame
    localparam int LN_W = LF_W + 1;                      // lines per frame

    // Configuration registers
    logic [FRAME_DIM_W-1:0] frame_width_reg;
    logic [FRAME_DIM_W-1:0] frame_height_reg;
    logic [TILE_DIM_W-1:0]  tile_width_reg;
    logic [TILE_DIM_W-1:0]  tile_height_reg;

    // Compare stage
    logic s1_valid_reg, s1_valid_next;
    logic s1_diff_reg;

    // Position and tally state
    logic [WL_W-1:0]             word_in_line_reg, word_in_line_next;
    logic [TILE_WORD_W-1:0]      word_in_tile_reg, word_in_tile_next;
    logic [WL_W-1:0]             tile_column_reg, tile_column_next;
    logic [TILE_LINE_W-1:0]      line_in_tile_reg, line_in_tile_next;
    logic [LF_W-1:0]             line_in_frame_reg, line_in_frame_next;
    logic [LF_W-1:0]             tile_row_reg, tile_row_next;
    logic [MAX_TILE_COLUMNS-1:0] dirty_mask_reg, dirty_mask_next;
    logic [CHANGED_W-1:0]        changed_count_reg, changed_count_next;

    // Result register
    logic        out_valid_reg, out_valid_next;
    row_result_t out_word_reg, out_word_next;

    // Clamped limits
    logic [12:0]            fw_clamped;
    logic [12:0]            fh_clamped;
    logic [TILE_DIM_W-1:0]  tw_clamped;
    logic [TILE_DIM_W-1:0]  th_clamped;
    logic [LW_W-1:0]        line_words;
    logic [LN_W-1:0]        lines;
    logic [7:0]             tile_words;
    logic [TILE_DIM_W-1:0]  tile_lines;

    logic                        line_end;
    logic                        last_line;
    logic                        row_done;
    logic                        process;
    logic                        in_accept;
    logic                        hit;
    logic [MAX_TILE_COLUMNS-1:0] col_bit;
    logic [MAX_TILE_COLUMNS-1:0] mask_upd;
    logic [CHANGED_W-1:0]        count_upd;

    // Write configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= RST_FRAME_WIDTH;
            frame_height_reg <= RST_FRAME_HEIGHT;
            tile_width_reg   <= RST_TILE_WIDTH;
            tile_height_reg  <= RST_TILE_HEIGHT;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_FRAME_WIDTH:  frame_width_reg  <= cfg_data;
                CFG_FRAME_HEIGHT: frame_height_reg <= cfg_data;
                CFG_TILE_WIDTH:   tile_width_reg   <= cfg_data[TILE_DIM_W-1:0];
                CFG_TILE_HEIGHT:  tile_height_reg  <= cfg_data[TILE_DIM_W-1:0];
                default: ;
            endcase
        end
    end

    // Clamp register values into their working ranges
    always_comb
    begin
        if (frame_width_reg < 12'd2)
            fw_clamped = 13'd2;
        else if (int'(frame_width_reg) > MAX_FRAME_WIDTH)
            fw_clamped = 13'(MAX_FRAME_WIDTH);
        else
            fw_clamped = 13'(frame_width_reg);

        if (frame_height_reg == '0)
            fh_clamped = 13'd1;
        else if (int'(frame_height_reg) > MAX_FRAME_HEIGHT)
            fh_clamped = 13'(MAX_FRAME_HEIGHT);
        else
            fh_clamped = 13'(frame_height_reg);

        if (tile_width_reg < 9'd2)
            tw_clamped = 9'd2;
        else if (tile_width_reg > 9'd256)
            tw_clamped = 9'd256;
        else
            tw_clamped = tile_width_reg;

        if (tile_height_reg == '0)
            th_clamped = 9'd1;
        else if (tile_height_reg > 9'd256)
            th_clamped = 9'd256;
        else
            th_clamped = tile_height_reg;

        line_words = LW_W'(fw_clamped >> 1);
        lines      = LN_W'(fh_clamped);
        tile_words = tw_clamped[8:1];
        tile_lines = th_clamped;
    end

    // Decide line and tile row ends, and whether the compare stage may advance
    always_comb
    begin
        line_end  = (LW_W'(word_in_line_reg) + LW_W'(1)) >= line_words;
        last_line = (LN_W'(line_in_frame_reg) + LN_W'(1)) >= lines;
        row_done  = line_end &&
                    (last_line || ((9'(line_in_tile_reg) + 9'd1) >= tile_lines));
        process   = s1_valid_reg && (!row_done || !out_valid_reg || !out_stall);
        in_stall  = s1_valid_reg && !process;
        in_accept = in_valid && !in_stall;
    end

    // Mark the current tile column; columns past the mask shift out to zero
    always_comb
    begin
        col_bit   = MAX_TILE_COLUMNS'(1) << tile_column_reg;
        hit       = s1_diff_reg && ((col_bit & ~dirty_mask_reg) != '0);
        mask_upd  = s1_diff_reg ? (dirty_mask_reg | col_bit) : dirty_mask_reg;
        count_upd = changed_count_reg + CHANGED_W'(hit);
    end

    // Advance counters and build the result
    always_comb
    begin
        word_in_line_next  = word_in_line_reg;
        word_in_tile_next  = word_in_tile_reg;
        tile_column_next   = tile_column_reg;
        line_in_tile_next  = line_in_tile_reg;
        line_in_frame_next = line_in_frame_reg;
        tile_row_next      = tile_row_reg;
        dirty_mask_next    = dirty_mask_reg;
        changed_count_next = changed_count_reg;

        out_word_next.row_mask      = ROW_MASK_W'(mask_upd);
        out_word_next.tile_row      = TILE_ROW_W'(tile_row_reg);
        out_word_next.changed_total = count_upd;
        out_word_next.frame_end     = last_line;

        if (process)
        begin
            dirty_mask_next    = mask_upd;
            changed_count_next = count_upd;
            if (line_end)
            begin
                word_in_line_next = '0;
                word_in_tile_next = '0;
                tile_column_next  = '0;
                if (row_done)
                begin
                    dirty_mask_next   = '0;
                    line_in_tile_next = '0;
                    if (last_line)
                    begin
                        line_in_frame_next = '0;
                        tile_row_next      = '0;
                        changed_count_next = '0;
                    end
                    else
                    begin
                        line_in_frame_next = line_in_frame_reg + LF_W'(1);
                        tile_row_next      = tile_row_reg + LF_W'(1);
                    end
                end
                else
                begin
                    line_in_tile_next  = line_in_tile_reg + TILE_LINE_W'(1);
                    line_in_frame_next = line_in_frame_reg + LF_W'(1);
                end
            end
            else
            begin
                word_in_line_next = word_in_line_reg + WL_W'(1);
                if ((8'(word_in_tile_reg) + 8'd1) >= tile_words)
                begin
                    word_in_tile_next = '0;
                    tile_column_next  = tile_column_reg + WL_W'(1);
                end
                else
                begin
                    word_in_tile_next = word_in_tile_reg + TILE_WORD_W'(1);
                end
            end
        end
    end

    // Hold or drop the compare stage and the result register
    always_comb
    begin
        if (in_accept)
            s1_valid_next = 1'b1;
        else if (process)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;

        if (process && row_done)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // Control and counter registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
            word_in_line_reg  <= '0;
            word_in_tile_reg  <= '0;
            tile_column_reg   <= '0;
            line_in_tile_reg  <= '0;
            line_in_frame_reg <= '0;
            tile_row_reg      <= '0;
            dirty_mask_reg    <= '0;
            changed_count_reg <= '0;
        end
        else
        begin
            s1_valid_reg      <= s1_valid_next;
            out_valid_reg     <= out_valid_next;
            word_in_line_reg  <= word_in_line_next;
            word_in_tile_reg  <= word_in_tile_next;
            tile_column_reg   <= tile_column_next;
            line_in_tile_reg  <= line_in_tile_next;
            line_in_frame_reg <= line_in_frame_next;
            tile_row_reg      <= tile_row_next;
            dirty_mask_reg    <= dirty_mask_next;
            changed_count_reg <= changed_count_next;
        end
    end

    // Payload registers: compare result and result word
    always_ff @(posedge clk)
    begin
        if (in_accept)
            s1_diff_reg <= (in_word.current_pair != in_word.previous_pair);
        if (process && row_done)
            out_word_reg <= out_word_next;
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

`ifndef NO_ASSERTIONS
    // A held result is never overwritten
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |-> !(process && row_done))
        else $error("result overwritten while stalled");

    // Input is only stalled while the compare stage is occupied
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> s1_valid_reg)
        else $error("input stalled with empty compare stage");

    // Tile column never runs ahead of the word position in the line
    a_column_bound: assert property (@(posedge clk) disable iff (!rst_n)
        tile_column_reg <= word_in_line_reg)
        else $error("tile column ahead of word position");

    // Frame end clears the running count and row index
    a_frame_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (process && row_done && last_line) |=>
            (changed_count_reg == '0) && (tile_row_reg == '0))
        else $error("frame end did not clear tallies");

    // A row that is not the last advances the row index by one and clears the dirty mask
    a_row_step: assert property (@(posedge clk) disable iff (!rst_n)
        (process && row_done && !last_line) |=>
            (tile_row_reg == $past(tile_row_reg) + LF_W'(1)) && (dirty_mask_reg == '0))
        else $error("tile row index did not advance");
`endif

endmodule
